[src/swd_write_transfer_master_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the SWD write transfer master.
// Synthesis sees empty bodies; simulation gets clocked concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SWD_WRITE_TRANSFER_MASTER_ASSERT_SVH
`define SWD_WRITE_TRANSFER_MASTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swd write transfer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swd write transfer assertion failed");

`else

`define SWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/swd_wt_pkg.sv]
// ---------------------------------------------------------------------------
// swd_wt_pkg
// Types and fixed constants of the SWD write transfer master.
// ---------------------------------------------------------------------------
`default_nettype none

package swd_wt_pkg;

  localparam int unsigned DataBits     = 32;
  localparam int unsigned HeaderClocks = 8;
  localparam int unsigned AckBits      = 3;

  // Positions inside the request header.
  localparam logic [5:0] PosStart  = 6'd0;
  localparam logic [5:0] PosLastRq = 6'd4;
  localparam logic [5:0] PosParity = 6'd5;
  localparam logic [5:0] PosStop   = 6'd6;
  localparam logic [5:0] PosPark   = 6'd7;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  typedef logic [5:0] wire_idx_t;
  typedef logic [6:0] wire_pos_t;

  typedef struct packed {
    logic       cycle_valid;
    logic       drive_bit;
    logic       drive_enable;
    logic       busy_flag;
    logic       transfer_done;
    logic [2:0] ack_code;
  } result_t;

endpackage

`default_nettype wire

[src/swd_write_transfer_master.sv]
// ---------------------------------------------------------------------------
// swd_write_transfer_master
// Host side of one SWD write transfer, one wire clock per tick request while a transfer runs.
// The result of a request appears in the output register in the cycle after
// the request is accepted. Throughput: one request per cycle; the input
// stalls only while a finished result is held by a stalled output.
// Reset (rst_n low, synchronous): idle, turnaround of one clock, output empty.
// ---------------------------------------------------------------------------
`default_nettype none

module swd_write_transfer_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel: turnaround length.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_turnaround_cycles,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [3:0]  in_request_bits,
  input  wire logic [31:0] in_write_word,
  input  wire logic        in_line_level,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_cycle_valid,
  output logic             out_drive_bit,
  output logic             out_drive_enable,
  output logic             out_busy_flag,
  output logic             out_transfer_done,
  output logic [2:0]       out_ack_code
);

  import swd_wt_pkg::*;

  `include "swd_write_transfer_master_assert.svh"

  // -------------------------------------------------------------------------
  // State registers. Only the control state is reset; the request latch,
  // the data shifter, the parity and the acknowledge are always loaded by a
  // start request before a tick can read them.
  // -------------------------------------------------------------------------
  logic [2:0]  turnaround_r;
  logic        active_r,     active_nxt;
  wire_idx_t   idx_r,        idx_nxt;
  logic [3:0]  request_r,    request_nxt;
  logic [31:0] word_r,       word_nxt;
  logic        parity_r,     parity_nxt;
  logic [2:0]  ack_r,        ack_nxt;
  logic        out_valid_r,  out_valid_nxt;
  result_t     result_r,     result_nxt;

  logic        accept_in;

  // Phase boundaries, derived from the current turnaround on every tick so a
  // mid-transfer change behaves like the decoder sees it at that moment.
  wire_pos_t   pos;
  wire_pos_t   ack_start;
  wire_pos_t   ack_end;
  wire_pos_t   data_start;
  wire_pos_t   last_pos;
  wire_pos_t   ack_offset;
  logic [1:0]  req_sel;

  // The configuration register can always be written.
  assign cfg_ready = 1'b1;

  // One output register separates the two sides: a new request is taken
  // unless a finished result is still waiting on a stalled output.
  assign in_stall  = out_valid_r & out_stall;
  assign accept_in = in_valid & ~in_stall;

  assign pos        = {1'b0, idx_r};
  assign ack_start  = wire_pos_t'(HeaderClocks) + {4'b0, turnaround_r};
  assign ack_end    = ack_start + wire_pos_t'(AckBits);
  assign data_start = ack_end + {4'b0, turnaround_r};
  assign last_pos   = data_start + wire_pos_t'(DataBits);
  assign ack_offset = pos - ack_start;
  assign req_sel    = 2'(idx_r - 6'd1);

  // -------------------------------------------------------------------------
  // Wire clock decoder. A tick while active emits one wire clock; the phase
  // follows the index and turnaround: header, first turnaround, acknowledge,
  // second turnaround, data, and finally the data parity which ends the
  // transfer. Anything else (idle ticks, start requests) drives a parked 1.
  // -------------------------------------------------------------------------
  always_comb begin
    active_nxt  = active_r;
    idx_nxt     = idx_r;
    request_nxt = request_r;
    word_nxt    = word_r;
    parity_nxt  = parity_r;
    ack_nxt     = ack_r;

    result_nxt               = '0;
    result_nxt.drive_bit     = 1'b1;
    result_nxt.drive_enable  = 1'b1;

    if (accept_in) begin
      if (req_type_t'(in_req_type) == REQ_START) begin
        // A start while a transfer runs is dropped.
        if (!active_r) begin
          active_nxt  = 1'b1;
          idx_nxt     = '0;
          request_nxt = in_request_bits;
          word_nxt    = in_write_word;
          parity_nxt  = 1'b0;
          ack_nxt     = '0;
        end
      end else if (active_r) begin
        result_nxt.cycle_valid = 1'b1;
        if (idx_r == PosStart) begin
          result_nxt.drive_bit = 1'b1;
        end else if (idx_r <= PosLastRq) begin
          result_nxt.drive_bit = request_r[req_sel];
          parity_nxt           = parity_r ^ request_r[req_sel];
        end else if (idx_r == PosParity) begin
          result_nxt.drive_bit = parity_r;
          parity_nxt           = 1'b0;
        end else if (idx_r == PosStop) begin
          result_nxt.drive_bit = 1'b0;
        end else if (idx_r == PosPark) begin
          result_nxt.drive_bit = 1'b1;
        end else if (pos < ack_start) begin
          result_nxt.drive_enable = 1'b0;
          result_nxt.drive_bit    = 1'b0;
        end else if (pos < ack_end) begin
          // Target drives the acknowledge; the first sample lands in bit 0.
          result_nxt.drive_enable = 1'b0;
          result_nxt.drive_bit    = 1'b0;
          ack_nxt = ack_r | (3'({2'b0, in_line_level}) << ack_offset[1:0]);
        end else if (pos < data_start) begin
          result_nxt.drive_enable = 1'b0;
          result_nxt.drive_bit    = 1'b0;
        end else if (pos < last_pos) begin
          // Data goes out least significant bit first.
          result_nxt.drive_bit = word_r[0];
          parity_nxt           = parity_r ^ word_r[0];
          word_nxt             = {1'b0, word_r[31:1]};
        end else begin
          result_nxt.drive_bit     = parity_r;
          result_nxt.transfer_done = 1'b1;
          result_nxt.ack_code      = ack_r;
          active_nxt               = 1'b0;
        end
        idx_nxt = result_nxt.transfer_done ? '0 : idx_r + 6'd1;
      end
    end

    result_nxt.busy_flag = active_nxt;

    // The output register fills on every accepted request and empties when
    // the downstream side takes the result.
    if (accept_in) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turnaround_r <= 3'd1;
      active_r     <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        turnaround_r <= cfg_turnaround_cycles;
      end
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    request_r <= request_nxt;
    word_r    <= word_nxt;
    parity_r  <= parity_nxt;
    ack_r     <= ack_nxt;
    if (accept_in) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cycle_valid   = result_r.cycle_valid;
  assign out_drive_bit     = result_r.drive_bit;
  assign out_drive_enable  = result_r.drive_enable;
  assign out_busy_flag     = result_r.busy_flag;
  assign out_transfer_done = result_r.transfer_done;
  assign out_ack_code      = result_r.ack_code;

  // -------------------------------------------------------------------------
  // Checks.
  // -------------------------------------------------------------------------
  // An idle block always restarts from the first header clock.
  `SWD_ASSERT_IMP(a_idle_index_zero, clk, rst_n, !active_r, idx_r == '0)
  // The line is never reported high while the host is not driving it.
  `SWD_ASSERT_IMP(a_float_low, clk, rst_n, out_valid_r && !result_r.drive_enable,
                  !result_r.drive_bit)
  // The final data parity clock ends the transfer and is a real wire clock.
  `SWD_ASSERT_IMP(a_done_ends, clk, rst_n, out_valid_r && result_r.transfer_done,
                  result_r.cycle_valid && !result_r.busy_flag)
  // A completed tick of the last clock leaves the block idle.
  `SWD_ASSERT_NXT(a_done_idle, clk, rst_n, accept_in && result_nxt.transfer_done,
                  !active_r)

endmodule

`default_nettype wire

[dv/swd_write_transfer_master_tb.sv]
// ----------------------------------------------------------------------------
// SWD write transfer master testbench
// Drives start and tick requests into the transfer master and predicts every
// result with a behavioral serializer kept inside this module. The run covers
// the shortest, the reset and the widest turnaround settings along with random
// ones, including a change in the middle of a transfer.
// The random transfers use the four idling modes and one long receiver
// hold-off. Each result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_write_transfer_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swd_wt_pkg::*;

  // A stretch this long with no handshake on any channel means the block hung.
  localparam int unsigned QuietLimit = 2000;
  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int unsigned LongHold = 300;

  // One request on the input channel, the fields as the ports carry them.
  typedef struct packed {
    req_type_t   kind;
    logic [3:0]  request_bits;
    logic [31:0] write_word;
    logic        line_level;
  } swd_request_t;

  // Level patterns for the line during a transfer (used by the ack samples).
  typedef enum int {
    LINE_LOW,
    LINE_HIGH,
    LINE_RANDOM
  } line_pattern_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block. Every input starts at a known
  // value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_turnaround_cycles = 3'd1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b1;
  logic [3:0]  in_request_bits = 4'd0;
  logic [31:0] in_write_word = 32'd0;
  logic        in_line_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_cycle_valid;
  logic        out_drive_bit;
  logic        out_drive_enable;
  logic        out_busy_flag;
  logic        out_transfer_done;
  logic [2:0]  out_ack_code;

  always #5 clk = ~clk;

  swd_write_transfer_master u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_turnaround_cycles (cfg_turnaround_cycles),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_request_bits       (in_request_bits),
    .in_write_word         (in_write_word),
    .in_line_level         (in_line_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_cycle_valid       (out_cycle_valid),
    .out_drive_bit         (out_drive_bit),
    .out_drive_enable      (out_drive_enable),
    .out_busy_flag         (out_busy_flag),
    .out_transfer_done     (out_transfer_done),
    .out_ack_code          (out_ack_code)
  );

  // --------------------------------------------------------------------------
  // Testbench bookkeeping.
  // --------------------------------------------------------------------------
  swd_request_t pending_requests[$];   // requests not yet offered to the block
  result_t      expected_clocks[$];    // predicted results, oldest first
  swd_request_t offered;               // the request currently on the input port
  result_t      predicted;
  result_t      awaited;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  hold_left = 0;
  bit           long_hold_request = 1'b0;

  // Serializer state as the block should hold it. It is reset once with the
  // block, so the declaration values are the reset values.
  logic        xfer_busy = 1'b0;
  wire_idx_t   xfer_index = '0;
  logic [3:0]  latched_request = '0;
  logic [31:0] data_shift = '0;
  logic        parity_acc = 1'b0;
  logic [2:0]  ack_bits = '0;
  logic [2:0]  turnaround = 3'd1;

  function automatic bit coin(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Works out the result of one accepted request and moves the serializer on.
  // The phase boundaries are decoded from the index with the turnaround that
  // holds now. A setting changed in the middle of a transfer therefore shifts
  // the phases under the running index.
  function automatic result_t predict_wire_clock(swd_request_t r);
    result_t     res;
    int unsigned ack_start;
    int unsigned data_start;
    int unsigned last_pos;
    int unsigned p;
    res = '0;
    res.drive_bit = 1'b1;
    res.drive_enable = 1'b1;
    ack_start = HeaderClocks + 32'(turnaround);
    data_start = ack_start + AckBits + 32'(turnaround);
    last_pos = data_start + DataBits;
    p = 32'(xfer_index);
    if (r.kind == REQ_START) begin
      // A start while a transfer runs is dropped without a trace.
      if (!xfer_busy) begin
        xfer_busy = 1'b1;
        xfer_index = '0;
        latched_request = r.request_bits;
        data_shift = r.write_word;
        parity_acc = 1'b0;
        ack_bits = '0;
      end
    end else if (xfer_busy) begin
      res.cycle_valid = 1'b1;
      if (p == PosStart) begin
        res.drive_bit = 1'b1;
      end else if (p <= PosLastRq) begin
        res.drive_bit = latched_request[2'(p - 1)];
        parity_acc ^= res.drive_bit;
      end else if (p == PosParity) begin
        res.drive_bit = parity_acc;
        parity_acc = 1'b0;
      end else if (p == PosStop) begin
        res.drive_bit = 1'b0;
      end else if (p == PosPark) begin
        res.drive_bit = 1'b1;
      end else if (p < ack_start) begin
        res.drive_enable = 1'b0;
        res.drive_bit = 1'b0;
      end else if (p < ack_start + AckBits) begin
        res.drive_enable = 1'b0;
        res.drive_bit = 1'b0;
        ack_bits[2'(p - ack_start)] = ack_bits[2'(p - ack_start)] | r.line_level;
      end else if (p < data_start) begin
        res.drive_enable = 1'b0;
        res.drive_bit = 1'b0;
      end else if (p < last_pos) begin
        res.drive_bit = data_shift[0];
        parity_acc ^= data_shift[0];
        data_shift = data_shift >> 1;
      end else begin
        // At or past the final position: data parity goes out and the
        // transfer ends, whatever the index.
        res.drive_bit = parity_acc;
        res.transfer_done = 1'b1;
        res.ack_code = ack_bits;
        xfer_busy = 1'b0;
      end
      xfer_index = res.transfer_done ? wire_idx_t'(0) : wire_idx_t'(p + 1);
    end
    res.busy_flag = xfer_busy;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the pending requests in order. A request stays on the
  // port, unchanged, until it is accepted. The gaps between requests are
  // drawn independently of the stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = predict_wire_clock(offered);
        expected_clocks.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && !coin(sender_idle_pct)) begin
          offered = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= offered.kind;
          in_request_bits <= offered.request_bits;
          in_write_word <= offered.write_word;
          in_line_level <= offered.line_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall. A long hold-off asked for by the sequence is counted
  // here. Otherwise the stall is drawn each cycle at the current rate.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (long_hold_request) begin
      long_hold_request = 1'b0;
      hold_left = LongHold;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= coin(receiver_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_clocks.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        awaited = expected_clocks.pop_front();
        if (out_cycle_valid !== awaited.cycle_valid)
          report_mismatch("cycle_valid", 32'(out_cycle_valid),
                          32'(awaited.cycle_valid));
        if (out_drive_bit !== awaited.drive_bit)
          report_mismatch("drive_bit", 32'(out_drive_bit), 32'(awaited.drive_bit));
        if (out_drive_enable !== awaited.drive_enable)
          report_mismatch("drive_enable", 32'(out_drive_enable),
                          32'(awaited.drive_enable));
        if (out_busy_flag !== awaited.busy_flag)
          report_mismatch("busy_flag", 32'(out_busy_flag), 32'(awaited.busy_flag));
        if (out_transfer_done !== awaited.transfer_done)
          report_mismatch("transfer_done", 32'(out_transfer_done),
                          32'(awaited.transfer_done));
        if (out_ack_code !== awaited.ack_code)
          report_mismatch("ack_code", 32'(out_ack_code), 32'(awaited.ack_code));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake on any channel restarts the count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no handshake for %0d cycles", QuietLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers.
  // --------------------------------------------------------------------------
  function automatic logic pick_level(line_pattern_t pattern);
    case (pattern)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1, 0));
    endcase
  endfunction

  // The address and data fields of a tick are ignored by the block, so they
  // carry random bits.
  function automatic swd_request_t make_tick(logic level);
    swd_request_t r;
    r.kind = REQ_TICK;
    r.request_bits = 4'($urandom);
    r.write_word = $urandom;
    r.line_level = level;
    return r;
  endfunction

  function automatic swd_request_t make_start(logic [3:0] rq, logic [31:0] word);
    swd_request_t r;
    r.kind = REQ_START;
    r.request_bits = rq;
    r.write_word = word;
    r.line_level = 1'($urandom_range(1, 0));
    return r;
  endfunction

  // Queues a start and exactly the ticks that the current turnaround needs.
  // With noise, an idle tick may come first, and one start that must be
  // ignored lands somewhere inside the transfer.
  task automatic queue_transfer(logic [3:0] rq, logic [31:0] word,
                                line_pattern_t pattern, bit noisy);
    int unsigned clocks;
    int unsigned stray_at;
    clocks = HeaderClocks + AckBits + DataBits + 1 + 2 * turnaround;
    stray_at = $urandom_range(clocks - 1, 1);
    if (noisy && coin(50))
      pending_requests.push_back(make_tick(pick_level(LINE_RANDOM)));
    pending_requests.push_back(make_start(rq, word));
    for (int unsigned i = 0; i < clocks; i++) begin
      if (noisy && i == stray_at)
        pending_requests.push_back(make_start(4'($urandom), $urandom));
      pending_requests.push_back(make_tick(pick_level(pattern)));
    end
  endtask

  // Returns once every queued request has been accepted and answered.
  task automatic wait_for_drain();
    do
      @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_clocks.size() != 0);
  endtask

  // Writes the turnaround register. The sequence only calls this while the
  // block has nothing in flight, so the prediction takes the new value at
  // the write.
  task automatic write_turnaround(logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_turnaround_cycles <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    turnaround = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
      default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset turnaround of one clock. An idle tick comes
    // first. A transfer is then stopped one tick short of its parity clock.
    // The turnaround is cut to zero, so the index already lies past the new
    // final position: the next tick must send the parity and end the
    // transfer. One idle tick follows.
    pending_requests.push_back(make_tick(1'b1));
    pending_requests.push_back(make_start(4'h5, 32'h1234_5678));
    for (int unsigned i = 0; i < HeaderClocks + AckBits + DataBits + 2; i++)
      pending_requests.push_back(make_tick(pick_level(LINE_RANDOM)));
    wait_for_drain();
    write_turnaround(3'd0);
    pending_requests.push_back(make_tick(1'b0));
    pending_requests.push_back(make_tick(1'b1));
    wait_for_drain();

    // Widest turnaround, all-ones request and word, the line high for an
    // ack of all ones, and a start ignored while busy.
    write_turnaround(3'd7);
    queue_transfer(4'hF, 32'hFFFF_FFFF, LINE_HIGH, 1'b1);
    wait_for_drain();

    // No turnaround at all, all-zero request and word, the line low.
    write_turnaround(3'd0);
    queue_transfer(4'h0, 32'h0000_0000, LINE_LOW, 1'b0);
    pending_requests.push_back(make_tick(1'b0));
    wait_for_drain();

    // Random part: five phases of three transfers each. The phases cycle
    // through the idling modes. The setting changes between phases, and
    // the last phase holds the receiver off for a long stretch while the sender
    // keeps offering requests.
    for (int unsigned phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_turnaround(3'd4);
        1:       write_turnaround(3'd1);
        2:       write_turnaround(3'($urandom_range(7, 0)));
        default: write_turnaround(3'($urandom_range(4, 1)));
      endcase
      set_idling(phase % 4);
      if (phase == 4)
        long_hold_request = 1'b1;
      for (int unsigned n = 0; n < 3; n++)
        queue_transfer(4'($urandom), $urandom, LINE_RANDOM, coin(30));
      wait_for_drain();
    end

    // Allow a margin for any result still in the output register or any stray one.
    repeat (8) @(posedge clk);
    if (expected_clocks.size() != 0)
      report_mismatch("results never arrived", 32'd0, 32'(expected_clocks.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[swd_write_transfer_master.f]
+incdir+src
src/swd_wt_pkg.sv
src/swd_write_transfer_master.sv
dv/swd_write_transfer_master_tb.sv
